### rtl/itc_pkg.sv
// shared types, constants and rounding functions of the intonation tone coder
package itc_pkg;

   // fixed-point layout
   localparam int FRACTION_BITS = 12;
   localparam int PITCH_W       = 16;
   localparam int STEP_W        = 13;
   localparam int LVL_W         = PITCH_W + 4;          // signed Q4.13 levels
   localparam int PROD_W        = LVL_W + STEP_W + 1;   // level delta times step
   localparam int ACC_W         = PROD_W + 2;           // rounding headroom
   localparam int SQ_W          = 2 * PITCH_W;
   localparam int SUM_W         = 48;
   localparam int TONE_W        = 3;

   // port widths
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_FIELD_W = TONE_W + PITCH_W + SUM_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // register reset values
   localparam logic [PITCH_W-1:0] MID_RESET    = PITCH_W'(30720);
   localparam logic [PITCH_W-1:0] RANGE_RESET  = PITCH_W'(4096);
   localparam logic [STEP_W-1:0]  HIGHER_RESET = STEP_W'(2048);
   localparam logic [STEP_W-1:0]  LOWER_RESET  = STEP_W'(2048);
   localparam logic [STEP_W-1:0]  UP_RESET     = STEP_W'(1024);
   localparam logic [STEP_W-1:0]  DOWN_RESET   = STEP_W'(1024);

   typedef enum logic [TONE_W-1:0] {
      TONE_M = 3'd0,
      TONE_S = 3'd1,
      TONE_T = 3'd2,
      TONE_H = 3'd3,
      TONE_U = 3'd4,
      TONE_B = 3'd5,
      TONE_L = 3'd6,
      TONE_D = 3'd7
   } tone_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MID_LEVEL   = 3'd0,
      CSR_PITCH_RANGE = 3'd1,
      CSR_HIGHER_STEP = 3'd2,
      CSR_LOWER_STEP  = 3'd3,
      CSR_UP_STEP     = 3'd4,
      CSR_DOWN_STEP   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_SQUARE,
      ST_WRITE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     capture;
      logic     issue;
      tone_type issue_tone;
      logic     compare;
      tone_type cmp_tone;
      logic     pick;
      logic     square;
      logic     write;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic jump_in;
      logic out_free;
   } status_type;

   // clamp a signed value to the unsigned pitch range
   function automatic logic [PITCH_W-1:0] sat_pitch(input logic signed [ACC_W-1:0] r);
      logic signed [ACC_W-1:0] top;
      top = $signed({{(ACC_W-PITCH_W){1'b0}}, {PITCH_W{1'b1}}});
      if (r < 0) begin
         return '0;
      end else if (r > top) begin
         return {PITCH_W{1'b1}};
      end else begin
         return r[PITCH_W-1:0];
      end
   endfunction

   // Q4.13 level to Q4.12, half up, saturated
   function automatic logic [PITCH_W-1:0] round_level(input logic signed [LVL_W-1:0] lvl2);
      logic signed [ACC_W-1:0] r;
      r = (ACC_W'(lvl2) + ACC_W'(1)) >>> 1;
      return sat_pitch(r);
   endfunction

   // Q4.(13+fraction) value to Q4.12, half up, saturated
   function automatic logic [PITCH_W-1:0] round_step(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + (ACC_W'(1) <<< FRACTION_BITS)) >>> (FRACTION_BITS + 1);
      return sat_pitch(r);
   endfunction

   function automatic logic [PITCH_W-1:0] abs_diff(input logic [PITCH_W-1:0] a,
                                                  input logic [PITCH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

### rtl/itc_ctrl.sv
// sequencer of the intonation tone coder: walks the candidate tones and the finish steps
module itc_ctrl import itc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type sts,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   tone_type  cnt_ff, cnt_in;

   // state and tone counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= TONE_S;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.issue_tone = cnt_ff;
      cmd.cmp_tone   = TONE_S;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = TONE_S;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sts.jump_in ? ST_PICK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // multiply for this tone, judge the one issued in the cycle before
            cmd.issue = 1'b1;
            if (cnt_ff != TONE_S) begin
               cmd.compare  = 1'b1;
               cmd.cmp_tone = tone_type'(TONE_W'(cnt_ff - 3'd1));
            end
            cnt_in = tone_type'(TONE_W'(cnt_ff + 3'd1));
            if (cnt_ff == TONE_D) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.compare  = 1'b1;
            cmd.cmp_tone = TONE_D;
            state_in     = ST_SQUARE;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/itc_dp.sv
// datapath of the intonation tone coder: registers, step multiplier, tone compare, error total
module itc_dp import itc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output status_type            sts,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [PITCH_W-1:0] mid_ff, range_ff;
   logic [STEP_W-1:0]  higher_ff, lower_ff, up_ff, down_ff;

   logic [PITCH_W-1:0] target_ff, prev_ff, best_est_ff, best_diff_ff;
   tone_type           best_tone_ff;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [SQ_W-1:0]    sq_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [LVL_W-1:0] mid2, range_s, top2, bot2, last2, t2;
   logic signed [LVL_W-1:0] lvl_sel, delta, dm, top_gap, bot_gap;
   logic [STEP_W-1:0]       step_sel;
   logic signed [ACC_W-1:0] step_acc;
   logic [PITCH_W-1:0]      cand_est, cand_diff, pick_est, err;
   tone_type                pick_tone;
   logic [SUM_W:0]          sum_wide;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff    <= MID_RESET;
         range_ff  <= RANGE_RESET;
         higher_ff <= HIGHER_RESET;
         lower_ff  <= LOWER_RESET;
         up_ff     <= UP_RESET;
         down_ff   <= DOWN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MID_LEVEL:   mid_ff    <= csr_wdata[PITCH_W-1:0];
            CSR_PITCH_RANGE: range_ff  <= csr_wdata[PITCH_W-1:0];
            CSR_HIGHER_STEP: higher_ff <= csr_wdata[STEP_W-1:0];
            CSR_LOWER_STEP:  lower_ff  <= csr_wdata[STEP_W-1:0];
            CSR_UP_STEP:     up_ff     <= csr_wdata[STEP_W-1:0];
            CSR_DOWN_STEP:   down_ff   <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // levels in Q4.13
   assign mid2    = $signed({{(LVL_W-PITCH_W-1){1'b0}}, mid_ff, 1'b0});
   assign range_s = $signed({{(LVL_W-PITCH_W){1'b0}}, range_ff});
   assign top2    = mid2 + range_s;
   assign bot2    = mid2 - range_s;
   assign last2   = $signed({{(LVL_W-PITCH_W-1){1'b0}}, prev_ff, 1'b0});
   assign t2      = $signed({{(LVL_W-PITCH_W-1){1'b0}}, target_ff, 1'b0});

   // step multiplier operands
   always_comb begin
      unique case (cmd.issue_tone)
         TONE_H:  begin lvl_sel = top2; step_sel = higher_ff; end
         TONE_U:  begin lvl_sel = top2; step_sel = up_ff;     end
         TONE_L:  begin lvl_sel = bot2; step_sel = lower_ff;  end
         TONE_D:  begin lvl_sel = bot2; step_sel = down_ff;   end
         default: begin lvl_sel = top2; step_sel = higher_ff; end
      endcase
   end

   assign delta   = lvl_sel - last2;
   assign prod_in = PROD_W'(delta) * PROD_W'($signed({1'b0, step_sel}));

   // candidate estimate for the tone being judged
   assign step_acc = ACC_W'(prod_ff) + (ACC_W'(last2) <<< FRACTION_BITS);

   always_comb begin
      unique case (cmd.cmp_tone)
         TONE_M:  cand_est = mid_ff;
         TONE_S:  cand_est = prev_ff;
         TONE_T:  cand_est = round_level(top2);
         TONE_B:  cand_est = round_level(bot2);
         default: cand_est = round_step(step_acc);
      endcase
   end

   assign cand_diff = abs_diff(cand_est, target_ff);

   // pause or first word: nearest of top, bottom, mid
   assign dm      = (t2 >= mid2) ? (t2 - mid2) : (mid2 - t2);
   assign top_gap = top2 - t2;
   assign bot_gap = t2 - bot2;

   always_comb begin
      priority if (top_gap < dm) begin
         pick_tone = TONE_T;
         pick_est  = round_level(top2);
      end else if (bot_gap < dm) begin
         pick_tone = TONE_B;
         pick_est  = round_level(bot2);
      end else begin
         pick_tone = TONE_M;
         pick_est  = mid_ff;
      end
   end

   // saturating error total
   assign err      = abs_diff(best_est_ff, target_ff);
   assign sum_wide = {1'b0, total_ff} + (SUM_W + 1)'(sq_ff);
   assign total_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.capture && req_tuser[1]) begin
         prev_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.write) begin
         prev_ff  <= best_est_ff;
         total_ff <= total_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_ff <= req_tdata[PITCH_W-1:0];
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
      end
      if (cmd.compare && (cmd.cmp_tone == TONE_S || cand_diff < best_diff_ff)) begin
         best_tone_ff <= cmd.cmp_tone;
         best_est_ff  <= cand_est;
         best_diff_ff <= cand_diff;
      end else if (cmd.pick) begin
         best_tone_ff <= pick_tone;
         best_est_ff  <= pick_est;
      end
      if (cmd.square) begin
         sq_ff <= SQ_W'(err) * SQ_W'(err);
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_data_ff <= {{(RSP_DATA_W-RSP_FIELD_W){1'b0}}, total_in, best_est_ff, best_tone_ff};
      end
   end

   assign sts.jump_in  = |req_tuser;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

endmodule

### rtl/intonation_tone_coder_unit.sv
// top level of the intonation tone coder: sequencer plus datapath
// Codes one pitch target per input word into an intonation tone (M S T H U B L D), its
// Q4.12 estimate and a saturating Q24.24 running sum of squared errors. A word flagged
// first or after-pause is coded T, B or M by nearness to the key levels; any other word
// visits the seven tones S through D one per cycle on a shared step multiplier. The
// result sits in an output register, so the next word is taken while it waits; a
// result not taken stalls the following word in its last step only. The registers are to
// be written through the csr port while no word is in flight; the block itself does
// not enforce this.
module intonation_tone_coder_unit import itc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // target_pitch
   input  logic [REQ_USER_W-1:0] req_tuser,   // after_pause, first_item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // tone_code, estimate, error_sum, zero pad
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   itc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   itc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // one word in flight: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while another is in flight");

   // the sequencer drives at most one of capture, issue, pick, square and write at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.issue, cmd.pick, cmd.square, cmd.write}))
      else $error("overlapping sequencer steps");

   // a result is written only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule
